FILE: design/lpmt_pkg.sv
// Shared types, codes and helpers for the longest prefix match table.
// No dependencies; every other design file imports this package.
package lpmt_pkg;

    localparam int LPMT_ENTRIES = 64;
    localparam int ADDR_W       = 32;
    localparam int LEN_W        = 6;
    localparam int PORT_W       = 8;
    localparam int STAT_W       = 3;
    localparam int KIND_W       = 2;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

    // item kinds
    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_ADDED   = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL    = 3'd1;
    localparam logic [STAT_W-1:0] STAT_CLEARED = 3'd2;
    localparam logic [STAT_W-1:0] STAT_HIT     = 3'd3;
    localparam logic [STAT_W-1:0] STAT_MISS    = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_HOLD
    } t_state;

    // lookup token handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic [LEN_W-1:0]  best_len;
        logic [PORT_W-1:0] best_port;
    } t_token;

    // top len bits set; zero for len 0, all ones for len 32 and above
    function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        len_mask = ~({ADDR_W{1'b1}} >> len);
    endfunction

endpackage

FILE: design/lpmt_cell.sv
// One table entry of the prefix match chain, with its stage of the lookup token.
// Depends on lpmt_pkg.
module lpmt_cell
    import lpmt_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CNT_W = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_add,
    input  logic [CNT_W-1:0]  i_count,
    input  logic [ADDR_W-1:0] i_wr_prefix,
    input  logic [LEN_W-1:0]  i_wr_length,
    input  logic [PORT_W-1:0] i_wr_port,
    input  logic [ADDR_W-1:0] i_addr,
    input  t_token            i_token,
    output t_token            o_token
);

    logic [ADDR_W-1:0] r_prefix;
    logic [LEN_W-1:0]  r_length;
    logic [PORT_W-1:0] r_port;
    t_token            r_token;
    t_token            n_token;

    logic              w_live;
    logic              w_match;
    logic [ADDR_W-1:0] w_mask;

    // take the entry when the append slot lands here
    always_ff @(posedge i_clk) begin
        if (i_add && (i_count == CNT_W'(INDEX))) begin
            r_prefix <= i_wr_prefix;
            r_length <= i_wr_length;
            r_port   <= i_wr_port;
        end
    end

    assign w_live  = (CNT_W'(INDEX) < i_count);
    assign w_mask  = len_mask(r_length);
    assign w_match = w_live && (r_length > i_token.best_len)
                     && (((i_addr ^ r_prefix) & w_mask) == '0);

    always_comb begin
        n_token = i_token;
        if (w_match) begin
            n_token.best_len  = r_length;
            n_token.best_port = r_port;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token <= '0;
        end else begin
            r_token <= n_token;
        end
    end

    assign o_token = r_token;

endmodule

FILE: design/longest_prefix_match_table.sv
// IPv4 longest prefix match table. Add appends an entry (prefix, length, port),
// clear empties the table, lookup returns the port of the longest matching entry,
// the earliest one on a tie; zero-length entries never win. One beat in gives one
// beat out (kind 3 is taken and dropped without a result). The block works on one
// item at a time: a lookup holds off new input while its token walks the chain
// of entry cells one cell per cycle and until its result, held over any output
// stall, is loaded into the output register. Depends on lpmt_pkg and lpmt_cell.
module longest_prefix_match_table
    import lpmt_pkg::*;
#(
    parameter int TABLE_ENTRIES = LPMT_ENTRIES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [ADDR_W-1:0] i_prefix_value,
    input  logic [LEN_W-1:0]  i_prefix_length,
    input  logic [PORT_W-1:0] i_entry_port,
    input  logic [ADDR_W-1:0] i_lookup_address,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [STAT_W-1:0] o_status,
    output logic [PORT_W-1:0] o_chosen_port
);

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

    t_state            r_state;
    t_state            n_state;
    logic [CNT_W-1:0]  r_count;
    logic [ADDR_W-1:0] r_addr;
    logic              r_start;
    logic [STAT_W-1:0] r_res_status;
    logic [PORT_W-1:0] r_res_port;
    logic              r_out_valid;
    logic [STAT_W-1:0] r_status;
    logic [PORT_W-1:0] r_port;

    logic              w_accept;
    logic              w_full;
    logic              w_add;
    logic              w_out_free;
    logic              w_load_out;
    logic              w_load_res;
    logic [STAT_W-1:0] n_status;
    logic [PORT_W-1:0] n_port;
    logic [STAT_W-1:0] w_last_status;
    logic [PORT_W-1:0] w_last_port;
    logic [LEN_W-1:0]  w_length;
    t_token            w_tok [TABLE_ENTRIES+1];

    // the output register frees up this cycle if it is empty or being drained
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = (r_count == FULL_CNT);
    assign w_add      = w_accept && (i_kind == KIND_ADD) && !w_full;

    // clamp lengths above 32 to an exact match
    assign w_length = (i_prefix_length > MAX_LEN) ? MAX_LEN : i_prefix_length;

    // ------------------------------------------------------------------
    // cell chain: each cell owns one entry and one stage of the token
    // ------------------------------------------------------------------
    assign w_tok[0] = '{valid: r_start, best_len: '0, best_port: '0};

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        lpmt_cell #(
            .INDEX (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_add       (w_add),
            .i_count     (r_count),
            .i_wr_prefix (i_prefix_value),
            .i_wr_length (w_length),
            .i_wr_port   (i_entry_port),
            .i_addr      (r_addr),
            .i_token     (w_tok[g]),
            .o_token     (w_tok[g+1])
        );
    end

    // a nonzero best length means some entry matched
    assign w_last_status = (w_tok[TABLE_ENTRIES].best_len != '0) ? STAT_HIT : STAT_MISS;
    assign w_last_port   = (w_tok[TABLE_ENTRIES].best_len != '0)
                           ? w_tok[TABLE_ENTRIES].best_port : '0;

    // ------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_kind == KIND_LOOKUP)) n_state = S_WALK;
            end
            S_WALK: begin
                if (w_tok[TABLE_ENTRIES].valid) n_state = w_out_free ? S_IDLE : S_HOLD;
            end
            S_HOLD: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_load_out = 1'b0;
        w_load_res = 1'b0;
        n_status   = r_status;
        n_port     = r_port;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_kind)
                        KIND_ADD: begin
                            w_load_out = 1'b1;
                            n_status   = w_full ? STAT_FULL : STAT_ADDED;
                            n_port     = '0;
                        end
                        KIND_CLEAR: begin
                            w_load_out = 1'b1;
                            n_status   = STAT_CLEARED;
                            n_port     = '0;
                        end
                        default: ;  // lookup starts the walk, kind 3 is dropped
                    endcase
                end
            end
            S_WALK: begin
                if (w_tok[TABLE_ENTRIES].valid) begin
                    if (w_out_free) begin
                        w_load_out = 1'b1;
                        n_status   = w_last_status;
                        n_port     = w_last_port;
                    end else begin
                        w_load_res = 1'b1;
                    end
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_status   = r_res_status;
                    n_port     = r_res_port;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= w_accept && (i_kind == KIND_LOOKUP);
            if (w_accept && (i_kind == KIND_CLEAR)) begin
                r_count <= '0;
            end else if (w_add) begin
                r_count <= r_count + 1'b1;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers: hold the lookup address for the walk, park a stalled result
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_kind == KIND_LOOKUP)) r_addr <= i_lookup_address;
        if (w_load_res) begin
            r_res_status <= w_last_status;
            r_res_port   <= w_last_port;
        end
        if (w_load_out) begin
            r_status <= n_status;
            r_port   <= n_port;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_chosen_port = r_port;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count beyond table size");

    a_full_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_kind == KIND_ADD) && w_full) |=> (r_count == FULL_CNT))
        else $error("add on a full table changed the count");

    a_walk_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_kind == KIND_LOOKUP)) |=> (r_state == S_WALK) && r_start)
        else $error("lookup did not start its walk");

    a_token_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[TABLE_ENTRIES].valid |-> (r_state == S_WALK))
        else $error("lookup token left the chain outside a walk");

    a_port_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != STAT_HIT)) |-> (o_chosen_port == '0))
        else $error("nonzero port on a non-hit result");

endmodule

FILE: tb/lpmt_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the longest prefix match table: keeps a shadow forwarding table,
// predicts one route result per accepted add, clear or lookup beat and compares
// output beats. Depends on lpmt_pkg.
module lpmt_checker
    import lpmt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [ADDR_W-1:0] i_prefix_value,
    input  logic [LEN_W-1:0]  i_prefix_length,
    input  logic [PORT_W-1:0] i_entry_port,
    input  logic [ADDR_W-1:0] i_lookup_address,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [STAT_W-1:0] i_status,
    input  logic [PORT_W-1:0] i_chosen_port,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_hit_count,
    output int                o_full_count
);

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [PORT_W-1:0] port;
    } t_route_result;

    logic [ADDR_W-1:0] fwd_prefix [LPMT_ENTRIES];
    logic [LEN_W-1:0]  fwd_len    [LPMT_ENTRIES];
    logic [PORT_W-1:0] fwd_port   [LPMT_ENTRIES];
    int                fwd_count;
    t_route_result     route_q[$];

    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
        if (len == '0) begin
            return '0;
        end
        return {ADDR_W{1'b1}} << (ADDR_W - int'(len));
    endfunction

    // Apply one input beat to the shadow table and queue the route it should give.
    task automatic predict_route(
        input logic [KIND_W-1:0] kind,
        input logic [ADDR_W-1:0] pfx,
        input logic [LEN_W-1:0]  len,
        input logic [PORT_W-1:0] port,
        input logic [ADDR_W-1:0] addr
    );
        t_route_result     r;
        logic [LEN_W-1:0]  best_len;
        logic [ADDR_W-1:0] m;
        r = '0;
        case (kind)
            KIND_ADD: begin
                if (fwd_count >= LPMT_ENTRIES) begin
                    r.status = STAT_FULL;
                end else begin
                    fwd_prefix[fwd_count] = pfx;
                    fwd_len[fwd_count]    = (len > MAX_LEN) ? MAX_LEN : len;
                    fwd_port[fwd_count]   = port;
                    fwd_count++;
                    r.status = STAT_ADDED;
                end
            end
            KIND_CLEAR: begin
                fwd_count = 0;
                r.status  = STAT_CLEARED;
            end
            KIND_LOOKUP: begin
                best_len = '0;
                r.status = STAT_MISS;
                for (int i = 0; i < fwd_count; i++) begin
                    m = prefix_mask(fwd_len[i]);
                    // strictly longer only: earliest entry keeps a tie
                    if (fwd_len[i] > best_len && ((addr ^ fwd_prefix[i]) & m) == '0) begin
                        best_len = fwd_len[i];
                        r.status = STAT_HIT;
                        r.port   = fwd_port[i];
                    end
                end
            end
            default: return;
        endcase
        route_q.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_route_result want;
        if (!i_rst_n) begin
            fwd_count = 0;
            route_q.delete();
        end else begin
            // check the output beat first: it belongs to an older input
            if (i_out_valid && i_out_ready) begin
                if (route_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("[%0t] unexpected result beat: status %0d port %0d",
                                 $realtime, i_status, i_chosen_port);
                    end
                end else begin
                    want = route_q.pop_front();
                    if (i_status !== want.status || i_chosen_port !== want.port) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display({"[%0t] route mismatch: status exp %0d got %0d,",
                                      " port exp %0d got %0d"},
                                     $realtime, want.status, i_status, want.port,
                                     i_chosen_port);
                        end
                    end else if (want.status == STAT_HIT) begin
                        o_hit_count++;
                    end else if (want.status == STAT_FULL) begin
                        o_full_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_route(i_kind, i_prefix_value, i_prefix_length, i_entry_port,
                              i_lookup_address);
            end
        end
        o_pending = route_q.size();
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Top of the longest prefix match table testbench: clock, reset, stimulus, flow
// control on both channels and the verdict. Depends on lpmt_pkg and lpmt_checker.
module testbench;
    import lpmt_pkg::*;

    // kind 3 has no code in the package: the block takes the beat and drops it
    localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;

    localparam int ITEM_TARGET  = 1500;
    // quiet cycles tolerated: one lookup walk, the long output hold-off, the
    // longest sender and receiver gaps, all taken several times over
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 250;
    localparam int HOLD_AFTER   = 300;
    localparam int TAIL_CYCLES  = 2 * LPMT_ENTRIES + 20;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] prefix_value;
    logic [LEN_W-1:0]  prefix_length;
    logic [PORT_W-1:0] entry_port;
    logic [ADDR_W-1:0] lookup_address;
    logic              out_valid;
    logic              out_ready;
    logic [STAT_W-1:0] status;
    logic [PORT_W-1:0] chosen_port;

    int fail_count;
    int pending;
    int hit_count;
    int full_count;

    // stimulus bookkeeping; the prefixes only steer addresses toward matches
    logic [ADDR_W-1:0] known_pfx[$];
    logic [LEN_W-1:0]  known_len[$];
    bit                burst_mode;
    bit                holding;
    bit                held_off;
    int                beats_out;
    int                quiet_cycles;
    int                n_add, n_clear, n_lookup, n_ignored;

    longest_prefix_match_table dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_kind           (kind),
        .i_prefix_value   (prefix_value),
        .i_prefix_length  (prefix_length),
        .i_entry_port     (entry_port),
        .i_lookup_address (lookup_address),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_status         (status),
        .o_chosen_port    (chosen_port)
    );

    lpmt_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_kind           (kind),
        .i_prefix_value   (prefix_value),
        .i_prefix_length  (prefix_length),
        .i_entry_port     (entry_port),
        .i_lookup_address (lookup_address),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_status         (status),
        .i_chosen_port    (chosen_port),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_hit_count      (hit_count),
        .o_full_count     (full_count)
    );

    // 12 ns clock, low first
    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Gap length in cycles: mostly none or short, now and then a long one.
    // Burst mode drops gaps entirely so back-to-back stretches occur too.
    function automatic int pick_gap(input bit no_gaps);
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Prefix for an add: often a relative of a stored prefix so entries nest
    // and overlap, otherwise anything at all.
    function automatic logic [ADDR_W-1:0] pick_prefix();
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] keep;
        if (known_pfx.size() == 0 || $urandom_range(0, 2) == 0) begin
            return $urandom;
        end
        base = known_pfx[$urandom_range(0, known_pfx.size() - 1)];
        keep = ~(32'hFFFF_FFFF >> $urandom_range(0, 32));
        return (base & keep) | ($urandom & ~keep);
    endfunction

    // Length for an add: mostly 1..31, with zero, exactly 32 and the
    // saturating range above 32 mixed in.
    function automatic logic [LEN_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            return '0;
        end else if (r < 14) begin
            return LEN_W'($urandom_range(33, 63));
        end else if (r < 22) begin
            return MAX_LEN;
        end
        return LEN_W'($urandom_range(1, 31));
    endfunction

    // Address for a lookup: mostly inside a stored prefix with random host
    // bits, sometimes with one random bit flipped, sometimes anywhere.
    function automatic logic [ADDR_W-1:0] pick_address();
        int                idx;
        logic [ADDR_W-1:0] keep;
        logic [ADDR_W-1:0] a;
        if (known_pfx.size() == 0 || $urandom_range(0, 3) == 0) begin
            return $urandom;
        end
        idx  = $urandom_range(0, known_pfx.size() - 1);
        keep = ~(32'hFFFF_FFFF >> known_len[idx]);
        a    = (known_pfx[idx] & keep) | ($urandom & ~keep);
        if ($urandom_range(0, 4) == 0) begin
            a = a ^ (32'h1 << $urandom_range(0, 31));
        end
        return a;
    endfunction

    // Offer one input beat. Called at a falling edge; returns at the falling
    // edge after the beat is taken. Valid is left high so a back-to-back beat
    // needs no second assignment in the same step.
    task automatic send_item(
        input logic [KIND_W-1:0] k,
        input logic [ADDR_W-1:0] p,
        input logic [LEN_W-1:0]  l,
        input logic [PORT_W-1:0] pt,
        input logic [ADDR_W-1:0] a
    );
        int gap;
        gap = pick_gap(burst_mode);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        kind           <= k;
        prefix_value   <= p;
        prefix_length  <= l;
        entry_port     <= pt;
        lookup_address <= a;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        case (k)
            KIND_ADD: begin
                n_add++;
                if (known_pfx.size() < LPMT_ENTRIES) begin
                    known_pfx.push_back(p);
                    known_len.push_back(l);
                end
            end
            KIND_CLEAR: begin
                n_clear++;
                known_pfx.delete();
                known_len.delete();
            end
            KIND_LOOKUP: n_lookup++;
            default:     n_ignored++;
        endcase
    endtask

    // Unused fields of each kind carry random junk: the block must ignore them.
    task automatic add_entry(input logic [ADDR_W-1:0] p, input logic [LEN_W-1:0] l,
                             input logic [PORT_W-1:0] pt);
        send_item(KIND_ADD, p, l, pt, $urandom);
    endtask

    task automatic look_up(input logic [ADDR_W-1:0] a);
        send_item(KIND_LOOKUP, $urandom, LEN_W'($urandom), PORT_W'($urandom), a);
    endtask

    task automatic clear_table();
        send_item(KIND_CLEAR, $urandom, LEN_W'($urandom), PORT_W'($urandom), $urandom);
    endtask

    // Drop valid and hold the sender until every predicted result is out.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    // Count output beats; the receiver uses this to time its long hold-off.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            beats_out++;
        end
    end

    // Watchdog: end the run when neither channel moves a beat for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                         quiet_cycles, pending);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Receiver: runs of ready separated by random gaps. Once, after enough
    // results, hold ready low for a long stretch while the sender keeps
    // offering, so the block backs up and stalls its input.
    initial begin
        int run;
        int gap;
        out_ready = 1'b0;
        do @(negedge clk); while (!rst_n);
        forever begin
            if (!held_off && beats_out >= HOLD_AFTER) begin
                holding = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                holding  = 1'b0;
                held_off = 1'b1;
            end else begin
                run = $urandom_range(1, 24);
                out_ready <= 1'b1;
                repeat (run) @(negedge clk);
                gap = pick_gap(1'b0);
                if (gap > 0) begin
                    out_ready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        int episode;
        int n_adds;
        int n_looks;
        bit mixed;
        in_valid       = 1'b0;
        kind           = KIND_ADD;
        prefix_value   = '0;
        prefix_length  = '0;
        entry_port     = '0;
        lookup_address = '0;
        rst_n          = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty table, zero-length entry, exact and saturated
        // lengths, nesting, tie on equal lengths, ignored kind, clear.
        look_up(32'h0000_0000);
        look_up(32'hFFFF_FFFF);
        add_entry(32'h1234_5678, 6'd0, 8'h01);
        look_up(32'h1234_5678);
        add_entry(32'hFFFF_FFFF, 6'd32, 8'hFF);
        add_entry(32'h0A00_0001, 6'd63, 8'hAA);
        look_up(32'hFFFF_FFFF);
        look_up(32'h0A00_0001);
        look_up(32'h0A00_0000);
        add_entry(32'h0A00_0000, 6'd8, 8'h10);
        add_entry(32'h0AFF_FFFF, 6'd8, 8'h11);
        add_entry(32'h0A01_0000, 6'd16, 8'h16);
        look_up(32'h0A01_7777);
        look_up(32'h0A7F_0000);
        add_entry(32'h0000_0000, 6'd1, 8'h00);
        look_up(32'h7FFF_FFFF);
        add_entry(32'h8000_0000, 6'd1, 8'h81);
        look_up(32'hFFFF_FFFE);
        send_item(KIND_IGNORED, 32'hFFFF_FFFF, 6'h3F, 8'hFF, 32'hFFFF_FFFF);
        look_up(32'h0A01_0203);
        clear_table();
        look_up(32'h0A01_0203);
        wait_for_results();

        // Random episodes: mostly clear, a batch of adds, then lookups aimed at
        // the stored prefixes. Some skip the clear, some interleave adds with
        // lookups, and some overfill the table; the first one always does.
        episode = 0;
        while (n_add + n_clear + n_lookup < ITEM_TARGET) begin
            burst_mode = ($urandom_range(0, 3) == 0);
            mixed      = ($urandom_range(0, 4) == 0);
            if (episode == 0 || $urandom_range(0, 4) != 0) begin
                clear_table();
            end
            if (episode == 0) begin
                n_adds = LPMT_ENTRIES + 2;
            end else if ($urandom_range(0, 5) == 0) begin
                n_adds = $urandom_range(LPMT_ENTRIES - 8, LPMT_ENTRIES + 8);
            end else begin
                n_adds = $urandom_range(1, 20);
            end
            n_looks = $urandom_range(5, 30);
            while (n_adds + n_looks > 0) begin
                if ($urandom_range(0, 39) == 0) begin
                    send_item(KIND_IGNORED, $urandom, LEN_W'($urandom),
                              PORT_W'($urandom), $urandom);
                end
                if (n_adds > 0 && (!mixed || n_looks == 0 || $urandom_range(0, 1) == 0)) begin
                    add_entry(pick_prefix(), pick_length(), PORT_W'($urandom));
                    n_adds--;
                end else begin
                    look_up(pick_address());
                    n_looks--;
                end
            end
            // pause the sender now and then, but never during the hold-off
            if (!holding && $urandom_range(0, 5) == 0) begin
                wait_for_results();
            end
            episode++;
        end

        // Drain, then give the block time to show any stray beat.
        wait_for_results();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("ran %0d adds, %0d clears, %0d lookups and %0d ignored beats in %0d episodes",
                 n_add, n_clear, n_lookup, n_ignored, episode);
        $display("saw %0d lookup hits and %0d adds refused by a full table, %0d mismatches",
                 hit_count, full_count, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: longest_prefix_match_table.f
design/lpmt_pkg.sv
design/lpmt_cell.sv
design/longest_prefix_match_table.sv
tb/lpmt_checker.sv
tb/testbench.sv
